@@ hdl/pid_pkg.sv @@
package pid_pkg;

   // Field and datapath widths
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned GAIN_W      = 31;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned MUL_A_W     = DATA_W + 1;
   localparam int unsigned PROD_W      = 64;
   localparam int unsigned P_W         = PROD_W - FRAC_W;
   localparam int unsigned D_W         = P_W + 1;
   localparam int unsigned SUM_W       = D_W + 1;
   localparam int unsigned CSR_INDEX_W = 3;

   // Default digits retired per cycle by the divider (1, 2, 4 or 8)
   localparam int unsigned DIV_BITS_DEF = 2;

   // Bound applied to the derivative term before the final sum: 2^47
   localparam logic signed [PROD_W-1:0] TERM_LIMIT = 64'sh0000_8000_0000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_OUT_MIN    = 3'd3,
      CSR_OUT_MAX    = 3'd4,
      CSR_INT_LIMIT  = 3'd5,
      CSR_STEP_TIME  = 3'd6,
      CSR_RATE_DERIV = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]        gain_p;
      logic [GAIN_W-1:0]        gain_i;
      logic [GAIN_W-1:0]        gain_d;
      logic signed [DATA_W-1:0] out_min;
      logic signed [DATA_W-1:0] out_max;
      logic [GAIN_W-1:0]        integral_limit;
      logic [GAIN_W-1:0]        step_time;
      logic                     rate_derivative;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      gain_p:          31'd3277,
      gain_i:          31'd66,
      gain_d:          31'd655,
      out_min:         -32'sd32768,
      out_max:         32'sd32768,
      integral_limit:  31'd6554,
      step_time:       31'd655,
      rate_derivative: 1'b1
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_AH,
      ST_MUL_AL,
      ST_MUL_D,
      ST_ACC,
      ST_DIV,
      ST_SUM,
      ST_OUT
   } pid_state_type;

endpackage

@@ hdl/pid_csr.sv @@
module pid_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [pid_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pid_pkg::DATA_W-1:0]       csr_wdata,
   output pid_pkg::cfg_type                 cfg
);
   import pid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:     cfg_in.gain_p          = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:     cfg_in.gain_i          = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:     cfg_in.gain_d          = csr_wdata[GAIN_W-1:0];
            CSR_OUT_MIN:    cfg_in.out_min         = $signed(csr_wdata);
            CSR_OUT_MAX:    cfg_in.out_max         = $signed(csr_wdata);
            CSR_INT_LIMIT:  cfg_in.integral_limit  = csr_wdata[GAIN_W-1:0];
            CSR_STEP_TIME:  cfg_in.step_time       = csr_wdata[GAIN_W-1:0];
            CSR_RATE_DERIV: cfg_in.rate_derivative = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/pid_mul.sv @@
module pid_mul (
   input  logic                                clock,
   input  logic signed [pid_pkg::MUL_A_W-1:0]  mul_a,
   input  logic [pid_pkg::GAIN_W-1:0]          mul_b,
   output logic signed [pid_pkg::PROD_W-1:0]   prod
);
   import pid_pkg::*;

   logic signed [MUL_A_W+GAIN_W:0] full;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [PROD_W-1:0]       prod_in;

   // Signed by unsigned product; every use keeps the value inside 64 bits
   always_comb begin
      full    = mul_a * $signed({1'b0, mul_b});
      prod_in = full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/pid_div.sv @@
module pid_div #(
   parameter int unsigned DIV_BITS = pid_pkg::DIV_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               div_start,
   input  logic signed [pid_pkg::PROD_W-1:0]  div_num,
   input  logic [pid_pkg::GAIN_W-1:0]         div_den,
   output logic                               div_done,
   output logic signed [pid_pkg::PROD_W-1:0]  div_quo
);
   import pid_pkg::*;

   localparam int unsigned ITER  = PROD_W / DIV_BITS;
   localparam int unsigned CNT_W = $clog2(ITER);

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [GAIN_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [PROD_W-1:0] res_ff, res_in;

   logic [GAIN_W:0]   trial;
   logic [GAIN_W-1:0] rem_v;
   logic [PROD_W-1:0] quo_v;

   // Restoring division of magnitudes, DIV_BITS quotient digits per cycle
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {rem_v, quo_v[PROD_W-1]};
         quo_v = {quo_v[PROD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_den}) begin
            trial    = trial - {1'b0, div_den};
            quo_v[0] = 1'b1;
         end
         rem_v = trial[GAIN_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      fix_in  = fix_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ITER - 1);
         neg_in  = div_num[PROD_W-1];
         quo_in  = div_num[PROD_W-1] ? -div_num : div_num;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_v;
         quo_in = quo_v;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // apply the sign: truncation toward zero
         fix_in  = 1'b0;
         res_in  = neg_ff ? -quo_ff : quo_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign div_done = done_ff;
   assign div_quo  = $signed(res_ff);

endmodule

@@ hdl/pid_antiwindup_controller.sv @@
// Channel  Dir  Handshake             Word
// req      in   req_valid/req_stall   req_error_in, req_rate_in (signed Q16.16)
// rsp      out  rsp_valid/rsp_stall   rsp_drive_out (signed Q16.16)
// csr      in   csr_write_en          csr_index, csr_wdata (write only)
//
// Rate mode: an accepted word runs through MUL_P, MUL_I, MUL_AH, MUL_AL, MUL_D,
// ACC, SUM and OUT, where the result is registered; the next word is taken only
// back in IDLE. Difference mode with the derivative armed adds DIV for the divider.
// The single 33x31 multiplier is the shared unit: five products per word.
// reset is synchronous, active high; it restores the state, the CSR fields and the
// output valid flag, and clears the integral, the last error and the armed flag.
// req_stall is high from accept until the result is loaded into the output
// register; a held result does not block the next word, only its final load.
module pid_antiwindup_controller #(
   parameter int unsigned DIV_BITS = pid_pkg::DIV_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [pid_pkg::DATA_W-1:0]  req_error_in,
   input  logic signed [pid_pkg::DATA_W-1:0]  req_rate_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pid_pkg::DATA_W-1:0]  rsp_drive_out,
   input  logic                               csr_write_en,
   input  logic [pid_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pid_pkg::DATA_W-1:0]         csr_wdata
);
   import pid_pkg::*;

   cfg_type cfg;

   pid_state_type state_ff, state_in;

   // sampled input word
   logic signed [DATA_W-1:0]  err_smp_ff, err_smp_in;
   logic signed [DATA_W-1:0]  rate_smp_ff, rate_smp_in;
   logic                      zero_ff, zero_in;

   // working terms
   logic signed [MUL_A_W-1:0] diff_ff, diff_in;
   logic signed [P_W-1:0]     p_ff, p_in;
   logic [FRAC_W-1:0]         a_lo_ff, a_lo_in;
   logic signed [PROD_W-1:0]  inc_ff, inc_in;
   logic signed [D_W-1:0]     d_ff, d_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   // controller state
   logic signed [DATA_W-1:0]  integral_acc_ff, integral_acc_in;
   logic signed [DATA_W-1:0]  last_error_ff, last_error_in;
   logic                      armed_ff, armed_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_drive_out_ff, rsp_drive_out_in;

   // shared units
   logic signed [MUL_A_W-1:0] mul_a;
   logic [GAIN_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      div_start;
   logic                      div_done;
   logic signed [PROD_W-1:0]  div_quo;

   logic req_accept;
   logic rsp_free;
   logic diff_armed;

   // saturation helpers
   logic signed [PROD_W-1:0]  acc_wide, lim_pos, acc_sat;
   logic signed [D_W-1:0]     d_div_sat;
   logic signed [SUM_W-1:0]   omin_w, omax_w, drive_sat;

   pid_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   pid_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   pid_div #(
      .DIV_BITS (DIV_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (prod),
      .div_den   (cfg.step_time),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign diff_armed = !cfg.rate_derivative && armed_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // zero step time skips all arithmetic and leaves state alone
               state_in = (cfg.step_time == '0) ? ST_OUT : ST_MUL_P;
            end
         end
         ST_MUL_P:  state_in = ST_MUL_I;
         ST_MUL_I:  state_in = ST_MUL_AH;
         ST_MUL_AH: state_in = ST_MUL_AL;
         ST_MUL_AL: state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_ACC;
         ST_ACC:    state_in = diff_armed ? ST_DIV : ST_SUM;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:    state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------- sequencer outputs
   // Operand select for the shared multiplier, one product per multiply state; also req_stall and the divider start.
   always_comb begin
      req_stall = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_MUL_P: begin
            mul_a = $signed({err_smp_ff[DATA_W-1], err_smp_ff});
            mul_b = cfg.gain_p;
         end
         ST_MUL_I: begin
            mul_a = $signed({err_smp_ff[DATA_W-1], err_smp_ff});
            mul_b = cfg.gain_i;
         end
         ST_MUL_AH: begin
            // high half of A = floor(gain_i * err / 2^32), taken straight off the product
            mul_a = $signed({prod[PROD_W-1], prod[PROD_W-1:PROD_W-DATA_W]});
            mul_b = cfg.step_time;
         end
         ST_MUL_AL: begin
            // low 16 bits of A, unsigned
            mul_a = $signed({{(MUL_A_W-FRAC_W){1'b0}}, a_lo_ff});
            mul_b = cfg.step_time;
         end
         ST_MUL_D: begin
            mul_a = cfg.rate_derivative ? $signed({rate_smp_ff[DATA_W-1], rate_smp_ff})
                                        : diff_ff;
            mul_b = cfg.gain_d;
         end
         ST_ACC: begin
            div_start = diff_armed;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ----------------------------------------------------- saturation logic
   always_comb begin
      acc_wide = $signed({{(PROD_W-DATA_W){integral_acc_ff[DATA_W-1]}}, integral_acc_ff})
                 + inc_ff;
      lim_pos  = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.integral_limit});
      acc_sat  = acc_wide;
      if (acc_wide < -lim_pos) begin
         acc_sat = -lim_pos;
      end else if (acc_wide > lim_pos) begin
         acc_sat = lim_pos;
      end
   end

   always_comb begin
      d_div_sat = div_quo[D_W-1:0];
      if (div_quo > TERM_LIMIT) begin
         d_div_sat = TERM_LIMIT[D_W-1:0];
      end else if (div_quo < -TERM_LIMIT) begin
         d_div_sat = D_W'(-TERM_LIMIT);
      end
   end

   // raise to out_min first, then lower to out_max, so out_max wins on inverted limits
   always_comb begin
      omin_w    = $signed({{(SUM_W-DATA_W){cfg.out_min[DATA_W-1]}}, cfg.out_min});
      omax_w    = $signed({{(SUM_W-DATA_W){cfg.out_max[DATA_W-1]}}, cfg.out_max});
      drive_sat = sum_ff;
      if (drive_sat < omin_w) begin
         drive_sat = omin_w;
      end
      if (drive_sat > omax_w) begin
         drive_sat = omax_w;
      end
   end

   // ------------------------------------------------------- datapath next
   always_comb begin
      err_smp_in       = err_smp_ff;
      rate_smp_in      = rate_smp_ff;
      zero_in          = zero_ff;
      diff_in          = diff_ff;
      p_in             = p_ff;
      a_lo_in          = a_lo_ff;
      inc_in           = inc_ff;
      d_in             = d_ff;
      sum_in           = sum_ff;
      integral_acc_in  = integral_acc_ff;
      last_error_in    = last_error_ff;
      armed_in         = armed_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_drive_out_in = rsp_drive_out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               err_smp_in  = req_error_in;
               rate_smp_in = req_rate_in;
               zero_in     = (cfg.step_time == '0);
            end
         end
         ST_MUL_P: begin
            diff_in = $signed({err_smp_ff[DATA_W-1], err_smp_ff})
                      - $signed({last_error_ff[DATA_W-1], last_error_ff});
         end
         ST_MUL_I: begin
            // floor shift: drop the 16 fraction bits of the gain
            p_in = prod[PROD_W-1:FRAC_W];
         end
         ST_MUL_AH: begin
            a_lo_in = prod[2*FRAC_W-1:FRAC_W];
         end
         ST_MUL_AL: begin
            inc_in = prod;
         end
         ST_MUL_D: begin
            // add the low partial product, floored; it is never negative
            inc_in = inc_ff + $signed({{FRAC_W{1'b0}}, prod[PROD_W-1:FRAC_W]});
         end
         ST_ACC: begin
            integral_acc_in = acc_sat[DATA_W-1:0];
            if (cfg.rate_derivative) begin
               d_in = -$signed({prod[PROD_W-1], prod[PROD_W-1:FRAC_W]});
            end else begin
               if (!armed_ff) begin
                  // first difference sample: arm only
                  d_in     = '0;
                  armed_in = 1'b1;
               end
               last_error_in = err_smp_ff;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               d_in = d_div_sat;
            end
         end
         ST_SUM: begin
            sum_in = $signed({{(SUM_W-P_W){p_ff[P_W-1]}}, p_ff})
                     + $signed({{(SUM_W-DATA_W){integral_acc_ff[DATA_W-1]}}, integral_acc_ff})
                     + $signed({d_ff[D_W-1], d_ff});
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_drive_out_in = zero_ff ? '0 : drive_sat[DATA_W-1:0];
            end
         end
         default: begin
            rsp_drive_out_in = rsp_drive_out_ff;
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         integral_acc_ff <= '0;
         last_error_ff   <= '0;
         armed_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         integral_acc_ff <= integral_acc_in;
         last_error_ff   <= last_error_in;
         armed_ff        <= armed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_smp_ff       <= err_smp_in;
      rate_smp_ff      <= rate_smp_in;
      zero_ff          <= zero_in;
      diff_ff          <= diff_in;
      p_ff             <= p_in;
      a_lo_ff          <= a_lo_in;
      inc_ff           <= inc_in;
      d_ff             <= d_in;
      sum_ff           <= sum_in;
      rsp_drive_out_ff <= rsp_drive_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = rsp_drive_out_ff;

endmodule

@@ hdl/pid_chk.sv @@
module pid_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [pid_pkg::DATA_W-1:0]  rsp_drive_out
);
   import pid_pkg::*;

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // held result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_drive_out))
      else $error("rsp_drive_out changed while stalled");

   // one word at a time: the block goes busy right after it takes a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   // a new result comes out of a busy sequence and frees the input side
   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall && $past(req_stall))
      else $error("result loaded outside the final step");

endmodule

bind pid_antiwindup_controller pid_chk u_pid_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_drive_out (rsp_drive_out)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import pid_pkg::*;

   // Run length and guard
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   localparam int unsigned RANDOM_WORDS = 1650;
   localparam int unsigned TAIL_CYCLES  = 40;
   localparam int unsigned REPORT_CAP   = 100;

   // Handy Q16.16 values
   localparam logic signed [31:0] Q_ONE   = 32'sd65536;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [31:0] err_word;
      logic signed [31:0] rate_word;
   } sample_type;

   // DUT pins; the inputs are at known values from time zero
   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic signed [31:0]       req_error_in  = '0;
   logic signed [31:0]       req_rate_in   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic signed [31:0]       rsp_drive_out;
   logic                     csr_write_en  = 1'b0;
   csr_index_type            csr_index     = CSR_GAIN_P;
   logic [31:0]              csr_wdata     = '0;

   // Stimulus and scoreboard state
   sample_type               sample_q[$];
   logic signed [31:0]       drive_expect_q[$];
   int unsigned              words_pending = 0;
   int unsigned              mismatches    = 0;
   int unsigned              cycle_count   = 0;
   int unsigned              req_gap_left  = 0;
   int unsigned              rsp_stall_left = 0;
   bit                       req_calm      = 1'b0;
   bit                       rsp_calm      = 1'b0;
   sample_type               next_sample;

   // Controller shadow: register file plus integral, last error and armed flag
   cfg_type                  model_cfg      = CFG_RST;
   logic signed [31:0]       model_integral = '0;
   logic signed [31:0]       model_last_err = '0;
   bit                       model_armed    = 1'b0;

   pid_antiwindup_controller u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_error_in  (req_error_in),
      .req_rate_in   (req_rate_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive_out (rsp_drive_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_to(longint x, longint lo, longint hi);
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return x;
   endfunction

   // Work out the drive for one accepted word and advance the shadow state.
   // All products stay below 2^63, so longint holds them exactly; >>> floors.
   function automatic logic signed [31:0] next_drive(logic signed [31:0] err_w,
                                                     logic signed [31:0] rate_w);
      longint err, rate, last, dt, gp, gi, gd, lim, p, a, inc, acc, d, sum;
      err  = err_w;
      rate = rate_w;
      last = model_last_err;
      dt   = model_cfg.step_time;
      gp   = model_cfg.gain_p;
      gi   = model_cfg.gain_i;
      gd   = model_cfg.gain_d;
      lim  = model_cfg.integral_limit;

      // zero period: output zero, leave every piece of state alone
      if (dt == 0) return '0;

      p = (gp * err) >>> 16;

      // split the period into 16-bit halves so the product never overflows
      a   = (gi * err) >>> 16;
      inc = a * (dt / 65536) + ((a * (dt % 65536)) >>> 16);
      acc = clamp_to(longint'(model_integral) + inc, -lim, lim);
      model_integral = acc[31:0];

      if (model_cfg.rate_derivative) begin
         d = -((gd * rate) >>> 16);
      end else begin
         // first difference sample only arms the term
         if (model_armed) begin
            d = (gd * (err - last)) / dt;
         end else begin
            d = 0;
            model_armed = 1'b1;
         end
         model_last_err = err_w;
      end

      p   = clamp_to(p, -TERM_LIMIT, TERM_LIMIT);
      d   = clamp_to(d, -TERM_LIMIT, TERM_LIMIT);
      sum = p + acc + d;
      // raise to the floor first, then cap: with inverted limits the cap wins
      if (sum < longint'($signed(model_cfg.out_min))) sum = $signed(model_cfg.out_min);
      if (sum > longint'($signed(model_cfg.out_max))) sum = $signed(model_cfg.out_max);
      return sum[31:0];
   endfunction

   // Idle length: mostly none, some short, a few long; none at all while calm
   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 4))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      if (r < 55) return $signed(32'($urandom_range(0, 524287))) - 32'sd262144;
      if (r < 75) return $signed(32'($urandom_range(0, 67108863))) - 32'sd33554432;
      return $urandom;
   endfunction

   // Gains and the integral bound; bit 31 is junk the block must drop
   function automatic logic [31:0] pick_gain();
      int unsigned r;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 10) v = '0;
      else if (r < 20) v = 32'h7FFF_FFFF;
      else if (r < 75) v = $urandom_range(0, 262144);
      else v = $urandom;
      v[31] = $urandom_range(0, 1);
      return v;
   endfunction

   function automatic logic [31:0] pick_period();
      int unsigned r;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 6) v = '0;
      else if (r < 12) v = 32'd1;
      else if (r < 18) v = 32'h7FFF_FFFF;
      else if (r < 85) v = $urandom_range(1, 8192);
      else v = $urandom;
      v[31] = $urandom_range(0, 1);
      return v;
   endfunction

   task automatic report_mismatch(string what, logic signed [31:0] want,
                                  logic signed [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("%0t MISMATCH %s: want %0d got %0d", $time, what, want, got);
   endtask

   // One register write: drive for one edge, then drop the enable.
   // Mirror it into the shadow copy right away; the block is idle here.
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_GAIN_P:     model_cfg.gain_p          = value[30:0];
         CSR_GAIN_I:     model_cfg.gain_i          = value[30:0];
         CSR_GAIN_D:     model_cfg.gain_d          = value[30:0];
         CSR_OUT_MIN:    model_cfg.out_min         = value;
         CSR_OUT_MAX:    model_cfg.out_max         = value;
         CSR_INT_LIMIT:  model_cfg.integral_limit  = value[30:0];
         CSR_STEP_TIME:  model_cfg.step_time       = value[30:0];
         CSR_RATE_DERIV: model_cfg.rate_derivative = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic queue_sample(logic signed [31:0] err_w, logic signed [31:0] rate_w);
      sample_q.push_back('{err_word: err_w, rate_word: rate_w});
      words_pending++;
   endtask

   // Hold until every queued word has been taken and every drive has come back
   task automatic settle();
      while (words_pending != 0 || drive_expect_q.size() != 0) @(posedge clock);
   endtask

   // Driver: present one word at a time, hold it while stalled, and
   // predict its drive at the edge it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            drive_expect_q.push_back(next_drive(req_error_in, req_rate_in));
            words_pending--;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left != 0) begin
               req_gap_left <= req_gap_left - 1;
               req_valid    <= 1'b0;
            end else if (sample_q.size() != 0) begin
               next_sample   = sample_q.pop_front();
               req_error_in <= next_sample.err_word;
               req_rate_in  <= next_sample.rate_word;
               req_valid    <= 1'b1;
               req_gap_left <= pick_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken drive against the oldest prediction, and
   // throw stall stretches of random length at the result side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expect_q.size() == 0)
            report_mismatch("drive with no word outstanding", 'x, rsp_drive_out);
         else if (rsp_drive_out !== drive_expect_q[0])
            report_mismatch("drive_out", drive_expect_q[0], rsp_drive_out);
         if (drive_expect_q.size() != 0) void'(drive_expect_q.pop_front());
      end
      if (rsp_stall_left != 0) begin
         rsp_stall      <= 1'b1;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_stall      <= 1'b0;
         rsp_stall_left <= pick_gap(rsp_calm);
      end
   end

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned        random_words;
      int unsigned        n;
      bit                 smooth;
      logic signed [31:0] e;
      logic signed [31:0] lo;
      logic signed [31:0] hi;

      random_words = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Defaults out of reset, rate mode: field extremes
      @(negedge clock);
      queue_sample(32'sd0, 32'sd0);
      queue_sample(Q_ONE, 32'sd0);
      queue_sample(-Q_ONE, Q_ONE);
      queue_sample(S32_MAX, S32_MIN);
      queue_sample(S32_MIN, S32_MAX);
      queue_sample(-32'sd1, -32'sd1);

      // Difference mode; junk in the upper register bits must be dropped
      settle();
      write_csr(CSR_GAIN_P, 32'd131072);
      write_csr(CSR_GAIN_I, 32'h8000_8000);
      write_csr(CSR_GAIN_D, 32'd6554);
      write_csr(CSR_OUT_MIN, -32'sd65536000);
      write_csr(CSR_OUT_MAX, 32'sd65536000);
      write_csr(CSR_INT_LIMIT, 32'h8064_0000);
      write_csr(CSR_STEP_TIME, 32'd655);
      write_csr(CSR_RATE_DERIV, 32'hFFFF_FFFE);
      @(negedge clock);
      queue_sample(Q_ONE, 32'sd0);            // arms the difference term
      queue_sample(3 * Q_ONE, 32'sd5);
      queue_sample(-2 * Q_ONE, 32'sd0);
      queue_sample(-2 * Q_ONE, S32_MAX);      // rate is ignored here
      queue_sample(S32_MAX, 32'sd0);
      queue_sample(S32_MIN, 32'sd0);          // widest error swing

      // Register extremes: full gains, full output range, shortest period
      settle();
      write_csr(CSR_GAIN_P, 32'hFFFF_FFFF);
      write_csr(CSR_GAIN_I, 32'hFFFF_FFFF);
      write_csr(CSR_GAIN_D, 32'hFFFF_FFFF);
      write_csr(CSR_OUT_MIN, S32_MIN);
      write_csr(CSR_OUT_MAX, S32_MAX);
      write_csr(CSR_INT_LIMIT, 32'hFFFF_FFFF);
      write_csr(CSR_STEP_TIME, 32'h8000_0001);
      @(negedge clock);
      queue_sample(S32_MAX, 32'sd0);
      queue_sample(S32_MIN, 32'sd0);
      queue_sample(32'sd1, 32'sd0);
      queue_sample(S32_MIN, 32'sd0);
      settle();
      write_csr(CSR_STEP_TIME, 32'h7FFF_FFFF);   // longest period
      @(negedge clock);
      queue_sample(S32_MAX, 32'sd0);
      queue_sample(S32_MIN, 32'sd0);

      // Zero period: zero drive and frozen state, seen once the period returns
      settle();
      write_csr(CSR_GAIN_P, 32'd65536);
      write_csr(CSR_GAIN_I, 32'd65536);
      write_csr(CSR_GAIN_D, 32'd655);
      write_csr(CSR_STEP_TIME, 32'd0);
      @(negedge clock);
      queue_sample(5 * Q_ONE, Q_ONE);
      queue_sample(S32_MIN, S32_MAX);
      settle();
      write_csr(CSR_STEP_TIME, 32'd655);
      @(negedge clock);
      queue_sample(5 * Q_ONE, 32'sd0);

      // Inverted limits in rate mode: the cap wins
      settle();
      write_csr(CSR_OUT_MIN, 32'sd655360);
      write_csr(CSR_OUT_MAX, -32'sd655360);
      write_csr(CSR_RATE_DERIV, 32'd1);
      @(negedge clock);
      queue_sample(32'sd0, 32'sd0);
      queue_sample(S32_MAX, S32_MIN);

      // Zero gains and a zero integral bound
      settle();
      write_csr(CSR_GAIN_P, 32'd0);
      write_csr(CSR_GAIN_I, 32'd0);
      write_csr(CSR_GAIN_D, 32'd0);
      write_csr(CSR_INT_LIMIT, 32'd0);
      write_csr(CSR_OUT_MIN, -Q_ONE);
      write_csr(CSR_OUT_MAX, Q_ONE);
      @(negedge clock);
      queue_sample(S32_MAX, S32_MAX);
      queue_sample(S32_MIN, S32_MIN);

      // Random phases: fresh settings each time, written only when drained
      while (random_words < RANDOM_WORDS) begin
         settle();
         lo = pick_value();
         hi = pick_value();
         if ($urandom_range(0, 4) == 0) begin
            lo = S32_MIN;
            hi = S32_MAX;
         end
         if (lo > hi) begin
            e  = lo;
            lo = hi;
            hi = e;
         end
         // swap now and then so inverted limits keep turning up
         if ($urandom_range(0, 9) == 0) begin
            e  = lo;
            lo = hi;
            hi = e;
         end
         write_csr(CSR_GAIN_P, pick_gain());
         write_csr(CSR_GAIN_I, pick_gain());
         write_csr(CSR_GAIN_D, pick_gain());
         write_csr(CSR_OUT_MIN, lo);
         write_csr(CSR_OUT_MAX, hi);
         write_csr(CSR_INT_LIMIT, pick_gain());
         write_csr(CSR_STEP_TIME, pick_period());
         write_csr(CSR_RATE_DERIV, $urandom);

         @(negedge clock);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         // smooth phases track a slowly drifting error, like a real loop
         smooth = ($urandom_range(0, 2) == 0);
         n = $urandom_range(60, 140);
         e = pick_value();
         repeat (n) begin
            if (smooth) e = e + 32'($urandom_range(0, 8191)) - 32'd4096;
            else e = pick_value();
            queue_sample(e, pick_value());
         end
         random_words += n;
      end

      // Drain, then give a stray extra drive time to show up
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && drive_expect_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
